### rtl/eapa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder angle to page address package
// Shared widths, message codes, register indexes, reset values and the
// sequencer and divider types.
// ----------------------------------------------------------------------------
package eapa_pkg;

  // Field widths fixed by the frame layout and the register map
  localparam int ID_W        = 11;
  localparam int PAYLOAD_W   = 16;
  localparam int ELAPSED_W   = 31;
  localparam int OFFSET_W    = 18;
  localparam int STEP_W      = 17;
  localparam int ROW_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 18;

  // Angle datapath: degrees times 256, one full turn is 92160 = 45 << 11
  localparam int ANGLE_W     = 17;
  localparam int X_W         = 20;
  localparam int FULL_TURN_Q8 = 92160;
  localparam int HALF_TURN_Q8 = 46080;
  localparam int TURN_COEF    = 45;
  localparam int TURN_SHIFT   = 11;

  // Divider iteration counts
  localparam int DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] RATE_STEPS  = 5'd31;
  localparam logic [DIV_CNT_W-1:0] ANGLE_STEPS = 5'd17;

  localparam logic [ID_W-1:0] ID_AZIMUTH   = 11'h021;
  localparam logic [ID_W-1:0] ID_ELEVATION = 11'h041;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  localparam logic [ELAPSED_W-1:0] RATE_ALL_ONES = 31'h7fff_ffff;

  // Register reset values
  localparam logic [OFFSET_W-1:0] AZ_OFFSET_RST = 18'h3f5e6; // -2586
  localparam logic [OFFSET_W-1:0] EL_OFFSET_RST = 18'h0353d; // 13629
  localparam logic [STEP_W-1:0]   STEP_RST      = 17'd256;
  localparam logic [ROW_W-1:0]    ROW_RST       = 16'd360;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AZ_OFFSET  = 3'd0,
    CFG_EL_OFFSET  = 3'd1,
    CFG_AZ_STEP    = 3'd2,
    CFG_EL_STEP    = 3'd3,
    CFG_ROW_LENGTH = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RATE,
    ST_CHECK,
    ST_ANGLE,
    ST_WRAP,
    ST_DIV,
    ST_MUL,
    ST_SUM,
    ST_DONE
  } eapa_state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] steps;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### rtl/eapa_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder event channel
// Valid/ready channel that carries one CAN frame or timer tick request.
// ----------------------------------------------------------------------------
interface eapa_in_if;
  logic                            valid;
  logic                            ready;
  logic                            kind;
  logic [eapa_pkg::ID_W-1:0]       message_id;
  logic [eapa_pkg::PAYLOAD_W-1:0]  payload_word;
  logic [eapa_pkg::ELAPSED_W-1:0]  elapsed_us;

  modport source (output valid, kind, message_id, payload_word, elapsed_us, input ready);
  modport sink   (input valid, kind, message_id, payload_word, elapsed_us, output ready);
endinterface

### rtl/eapa_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page fetch result channel
// Valid/ready channel that carries one page address and rate request.
// ----------------------------------------------------------------------------
interface eapa_out_if #(
  parameter int PAGE_ADDRESS_BITS = 17
);
  logic                            valid;
  logic                            ready;
  logic [PAGE_ADDRESS_BITS-1:0]    page_address;
  logic                            fetch_valid;
  logic                            sequence_gap;
  logic                            rate_valid;
  logic [eapa_pkg::ELAPSED_W-1:0]  us_per_count;

  modport source (output valid, page_address, fetch_valid, sequence_gap, rate_valid,
                  us_per_count, input ready);
  modport sink   (input valid, page_address, fetch_valid, sequence_gap, rate_valid,
                  us_per_count, output ready);
endinterface

### rtl/eapa_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared restoring divider
// Radix-2 unsigned divider, one quotient bit per cycle; the dividend is
// left aligned and the caller picks how many bits to develop.
// ----------------------------------------------------------------------------
module eapa_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  eapa_pkg::div_ctrl_t            ctrl,
  input  logic [eapa_pkg::ELAPSED_W-1:0] dividend,
  input  logic [eapa_pkg::STEP_W-1:0]    divisor,
  output eapa_pkg::div_stat_t            stat,
  output logic [eapa_pkg::ELAPSED_W-1:0] quotient
);
  import eapa_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [STEP_W-1:0]    rem_r, rem_nxt;
  logic [STEP_W-1:0]    dsr_r, dsr_nxt;
  logic [ELAPSED_W-1:0] quo_r, quo_nxt;
  logic [STEP_W+1:0]    diff;
  logic                 fits;

  // Trial subtract of the divisor from the shifted partial remainder
  assign diff = {1'b0, rem_r, quo_r[ELAPSED_W-1]} - {2'b00, dsr_r};
  assign fits = ~diff[STEP_W+1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quo_nxt  = quo_r;
    if (ctrl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = ctrl.steps;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[STEP_W-1:0] : {rem_r[STEP_W-2:0], quo_r[ELAPSED_W-1]};
      quo_nxt = {quo_r[ELAPSED_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

### rtl/encoder_angle_to_page_address.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder angle to page address
// Tracks azimuth and elevation encoder counts from CAN frames and timer
// ticks, and turns each new azimuth into a page address; frames also give a rate.
// ----------------------------------------------------------------------------
// Takes one request at a time: in_req.ready is high only while the sequencer
// is idle, but a finished result may still sit in the output register while
// the next request is accepted. An elevation frame or an unknown identifier
// leaves the sequencer idle and gives no result. A timer tick converts both
// axes to angle indexes before ready returns; a negative elevation skips its
// division. An azimuth frame adds the rate division first; when the azimuth
// did not change it ends after the rate, and a zero count delta skips the
// rate division. The single radix-2 divider develops one quotient bit per
// cycle and is shared by the rate and both angle indexes. For offsets far
// out of range the angle wrap adds or subtracts further full turns, and a
// result that the sink has not yet taken holds the sequencer in its last
// state.
// ----------------------------------------------------------------------------
module encoder_angle_to_page_address #(
  parameter int ENCODER_BITS      = 14,
  parameter int PAGE_ADDRESS_BITS = 17
) (
  input  logic                            clk,
  input  logic                            rst_n,
  eapa_in_if.sink                         in_req,
  eapa_out_if.source                      out_res,
  input  logic                            cfg_we,
  input  logic [eapa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [eapa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import eapa_pkg::*;

  // Angle conversion: count * 45 << 11 >> ENCODER_BITS
  localparam int TW    = ENCODER_BITS + 6 + TURN_SHIFT;
  localparam int PROD_W = ANGLE_W + ROW_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam logic [SUM_W-1:0] PAGE_MAX =
    SUM_W'((64'd1 << PAGE_ADDRESS_BITS) - 64'd1);
  localparam logic signed [X_W-1:0] FULL_X = X_W'(FULL_TURN_Q8);
  localparam logic signed [X_W-1:0] HALF_X = X_W'(HALF_TURN_Q8);
  localparam logic [ANGLE_W-1:0]    HALF_A = ANGLE_W'(HALF_TURN_Q8);

  // Sequencer and encoder state
  eapa_state_t               state_r, state_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [ENCODER_BITS-1:0]   az_count_r, az_count_nxt;
  logic [ENCODER_BITS-1:0]   el_count_r, el_count_nxt;
  logic [ENCODER_BITS-1:0]   last_frame_r, last_frame_nxt;
  logic [ENCODER_BITS-1:0]   last_used_r, last_used_nxt;

  // Configuration registers
  logic [OFFSET_W-1:0]       az_offset_r, el_offset_r;
  logic [STEP_W-1:0]         az_step_r, el_step_r;
  logic [ROW_W-1:0]          row_length_r;

  // Working registers
  logic                      axis_el_r, axis_el_nxt;
  logic signed [X_W-1:0]     x_r, x_nxt;
  logic [ANGLE_W-1:0]        iaz_r, iaz_nxt;
  logic [ANGLE_W-1:0]        iel_r, iel_nxt;
  logic [PROD_W-1:0]         prod_r, prod_nxt;
  logic [PAGE_ADDRESS_BITS-1:0] page_r, page_nxt;
  logic                      fetch_r, fetch_nxt;
  logic                      gap_r, gap_nxt;
  logic                      rate_valid_r, rate_valid_nxt;
  logic [ELAPSED_W-1:0]      rate_r, rate_nxt;

  // Output register
  logic [PAGE_ADDRESS_BITS-1:0] o_page_r, o_page_nxt;
  logic                      o_fetch_r, o_fetch_nxt;
  logic                      o_gap_r, o_gap_nxt;
  logic                      o_rate_valid_r, o_rate_valid_nxt;
  logic [ELAPSED_W-1:0]      o_rate_r, o_rate_nxt;

  // Shared divider
  div_ctrl_t                 div_ctrl;
  div_stat_t                 div_stat;
  logic [ELAPSED_W-1:0]      div_dividend;
  logic [STEP_W-1:0]         div_divisor;
  logic [ELAPSED_W-1:0]      div_quotient;

  // Combinational helpers
  logic                      in_acc;
  logic [ENCODER_BITS-1:0]   in_count;
  logic [ENCODER_BITS-1:0]   delta;
  logic [ENCODER_BITS-1:0]   conv_count;
  logic [OFFSET_W-1:0]       conv_offset;
  logic [TW-1:0]             turn_full;
  logic [TW-1:0]             turn_shifted;
  logic [ANGLE_W-1:0]        turn_angle;
  logic signed [X_W-1:0]     x_base;
  logic [ANGLE_W-1:0]        m_angle;
  logic [STEP_W-1:0]         az_step_eff;
  logic [STEP_W-1:0]         el_step_eff;
  logic [SUM_W-1:0]          page_sum;

  eapa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quotient)
  );

  assign in_req.ready = (state_r == ST_IDLE);
  assign in_acc       = in_req.valid && in_req.ready;
  assign in_count     = in_req.payload_word[ENCODER_BITS-1:0];
  assign delta        = in_count - last_frame_r;

  // Count to degrees times 256 for the axis in work, minus its offset
  assign conv_count   = axis_el_r ? el_count_r : az_count_r;
  assign conv_offset  = axis_el_r ? el_offset_r : az_offset_r;
  assign turn_full    = TW'(conv_count) * TW'(TURN_COEF);
  assign turn_shifted = (turn_full << TURN_SHIFT) >> ENCODER_BITS;
  assign turn_angle   = turn_shifted[ANGLE_W-1:0];
  assign x_base       = $signed({{(X_W-ANGLE_W){1'b0}}, turn_angle})
                      - $signed({{(X_W-OFFSET_W){conv_offset[OFFSET_W-1]}}, conv_offset});
  assign m_angle      = x_r[ANGLE_W-1:0];

  // A step of zero counts as one
  assign az_step_eff  = (az_step_r == '0) ? STEP_W'(1) : az_step_r;
  assign el_step_eff  = (el_step_r == '0) ? STEP_W'(1) : el_step_r;

  assign page_sum     = SUM_W'(prod_r) + SUM_W'(iaz_r);

  always_comb begin
    state_nxt        = state_r;
    out_valid_nxt    = out_valid_r;
    az_count_nxt     = az_count_r;
    el_count_nxt     = el_count_r;
    last_frame_nxt   = last_frame_r;
    last_used_nxt    = last_used_r;
    axis_el_nxt      = axis_el_r;
    x_nxt            = x_r;
    iaz_nxt          = iaz_r;
    iel_nxt          = iel_r;
    prod_nxt         = prod_r;
    page_nxt         = page_r;
    fetch_nxt        = fetch_r;
    gap_nxt          = gap_r;
    rate_valid_nxt   = rate_valid_r;
    rate_nxt         = rate_r;
    o_page_nxt       = o_page_r;
    o_fetch_nxt      = o_fetch_r;
    o_gap_nxt        = o_gap_r;
    o_rate_valid_nxt = o_rate_valid_r;
    o_rate_nxt       = o_rate_r;
    div_ctrl         = '0;
    div_dividend     = '0;
    div_divisor      = '0;

    // Drop the held result once the sink takes it
    if (out_valid_r && out_res.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_req.kind == KIND_TICK) begin
            // Tick: advance azimuth, always fetch, no rate
            az_count_nxt   = az_count_r + 1'b1;
            rate_valid_nxt = 1'b0;
            rate_nxt       = '0;
            fetch_nxt      = 1'b1;
            gap_nxt        = (az_count_r != last_used_r);
            last_used_nxt  = az_count_r + 1'b1;
            axis_el_nxt    = 1'b0;
            state_nxt      = ST_ANGLE;
          end else if (in_req.message_id == ID_AZIMUTH) begin
            az_count_nxt   = in_count;
            last_frame_nxt = in_count;
            rate_valid_nxt = 1'b1;
            if (delta == '0) begin
              rate_nxt  = RATE_ALL_ONES;
              state_nxt = ST_CHECK;
            end else begin
              div_ctrl.start = 1'b1;
              div_ctrl.steps = RATE_STEPS;
              div_dividend   = in_req.elapsed_us;
              div_divisor    = STEP_W'(delta);
              state_nxt      = ST_RATE;
            end
          end else if (in_req.message_id == ID_ELEVATION) begin
            el_count_nxt = in_count;
          end
        end
      end

      ST_RATE: begin
        if (div_stat.done) begin
          rate_nxt  = div_quotient;
          state_nxt = ST_CHECK;
        end
      end

      ST_CHECK: begin
        if (last_used_r == az_count_r) begin
          // Azimuth unchanged: report the rate only
          fetch_nxt = 1'b0;
          page_nxt  = '0;
          gap_nxt   = 1'b0;
          state_nxt = ST_DONE;
        end else begin
          fetch_nxt     = 1'b1;
          gap_nxt       = (az_count_r != last_used_r + 1'b1);
          last_used_nxt = az_count_r;
          axis_el_nxt   = 1'b0;
          state_nxt     = ST_ANGLE;
        end
      end

      ST_ANGLE: begin
        // Elevation is biased by half a turn so the wrap lands in [-180,180)
        x_nxt     = axis_el_r ? x_base + HALF_X : x_base;
        state_nxt = ST_WRAP;
      end

      ST_WRAP: begin
        if (x_r[X_W-1]) begin
          x_nxt = x_r + FULL_X;
        end else if (x_r >= FULL_X) begin
          x_nxt = x_r - FULL_X;
        end else if (!axis_el_r) begin
          div_ctrl.start = 1'b1;
          div_ctrl.steps = ANGLE_STEPS;
          div_dividend   = {m_angle, {(ELAPSED_W-ANGLE_W){1'b0}}};
          div_divisor    = az_step_eff;
          state_nxt      = ST_DIV;
        end else if (m_angle < HALF_A) begin
          // Negative elevation clamps to the first row
          iel_nxt   = '0;
          state_nxt = ST_MUL;
        end else begin
          div_ctrl.start = 1'b1;
          div_ctrl.steps = ANGLE_STEPS;
          div_dividend   = {m_angle - HALF_A, {(ELAPSED_W-ANGLE_W){1'b0}}};
          div_divisor    = el_step_eff;
          state_nxt      = ST_DIV;
        end
      end

      ST_DIV: begin
        if (div_stat.done) begin
          if (!axis_el_r) begin
            iaz_nxt     = div_quotient[ANGLE_W-1:0];
            axis_el_nxt = 1'b1;
            state_nxt   = ST_ANGLE;
          end else begin
            iel_nxt   = div_quotient[ANGLE_W-1:0];
            state_nxt = ST_MUL;
          end
        end
      end

      ST_MUL: begin
        prod_nxt  = PROD_W'(iel_r) * PROD_W'(row_length_r);
        state_nxt = ST_SUM;
      end

      ST_SUM: begin
        page_nxt  = (page_sum > PAGE_MAX) ? '1 : page_sum[PAGE_ADDRESS_BITS-1:0];
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        // Hold until the output register is free
        if (!out_valid_r || out_res.ready) begin
          o_page_nxt       = page_r;
          o_fetch_nxt      = fetch_r;
          o_gap_nxt        = gap_r;
          o_rate_valid_nxt = rate_valid_r;
          o_rate_nxt       = rate_r;
          out_valid_nxt    = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      az_count_r   <= '0;
      el_count_r   <= '0;
      last_frame_r <= '0;
      last_used_r  <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      az_count_r   <= az_count_nxt;
      el_count_r   <= el_count_nxt;
      last_frame_r <= last_frame_nxt;
      last_used_r  <= last_used_nxt;
    end
  end

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      az_offset_r  <= AZ_OFFSET_RST;
      el_offset_r  <= EL_OFFSET_RST;
      az_step_r    <= STEP_RST;
      el_step_r    <= STEP_RST;
      row_length_r <= ROW_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_AZ_OFFSET:  az_offset_r  <= cfg_data[OFFSET_W-1:0];
        CFG_EL_OFFSET:  el_offset_r  <= cfg_data[OFFSET_W-1:0];
        CFG_AZ_STEP:    az_step_r    <= cfg_data[STEP_W-1:0];
        CFG_EL_STEP:    el_step_r    <= cfg_data[STEP_W-1:0];
        CFG_ROW_LENGTH: row_length_r <= cfg_data[ROW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    axis_el_r      <= axis_el_nxt;
    x_r            <= x_nxt;
    iaz_r          <= iaz_nxt;
    iel_r          <= iel_nxt;
    prod_r         <= prod_nxt;
    page_r         <= page_nxt;
    fetch_r        <= fetch_nxt;
    gap_r          <= gap_nxt;
    rate_valid_r   <= rate_valid_nxt;
    rate_r         <= rate_nxt;
    o_page_r       <= o_page_nxt;
    o_fetch_r      <= o_fetch_nxt;
    o_gap_r        <= o_gap_nxt;
    o_rate_valid_r <= o_rate_valid_nxt;
    o_rate_r       <= o_rate_nxt;
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.page_address = o_page_r;
  assign out_res.fetch_valid  = o_fetch_r;
  assign out_res.sequence_gap = o_gap_r;
  assign out_res.rate_valid   = o_rate_valid_r;
  assign out_res.us_per_count = o_rate_r;

  // A frame that is not an azimuth frame must leave the sequencer idle
  a_other_frame_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_req.kind == KIND_FRAME && in_req.message_id != ID_AZIMUTH)
      |=> (state_r == ST_IDLE))
    else $error("non-azimuth frame started the sequencer");

  // The divider finishes only while the sequencer waits for it
  a_div_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_RATE || state_r == ST_DIV))
    else $error("divider result arrived outside a wait state");

  // While waiting on the divider it must be running or finishing
  a_div_running: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RATE || state_r == ST_DIV) |-> (div_stat.busy || div_stat.done))
    else $error("sequencer waits on an idle divider");

  // A result without a fetch comes only from an unchanged azimuth frame
  a_no_fetch_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && !out_res.fetch_valid)
      |-> (out_res.rate_valid && !out_res.sequence_gap && out_res.page_address == '0))
    else $error("rate-only result carries page data");

endmodule
